// ----- hw/rtl/dbcs_aware_script_comment_stripper_defines.svh -----
// Assertion macros for the comment stripper.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef DBCS_AWARE_SCRIPT_COMMENT_STRIPPER_DEFINES_SVH
`define DBCS_AWARE_SCRIPT_COMMENT_STRIPPER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define DBCSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define DBCSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DBCSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DBCSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/dbcscs_pkg.sv -----
package dbcscs_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_HIGH  = 8'd127;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Scanner mode; codes 5 to 7 behave as normal text
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_STRING = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } scan_mode_t;

    // One queued job: up to two output words
    typedef struct packed {
        logic       pre_slash;  // flushed slash word goes out first
        logic       bvalid;     // final word carries a byte
        logic       done;       // final word closes the text
        logic [7:0] data;       // byte of the final word
    } q_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- hw/rtl/dbcscs_front.sv -----
module dbcscs_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] text_byte
    input  logic                      s_tlast,   // end_of_text
    input  dbcscs_pkg::queue_status_t q_status,
    output logic                      push,
    output dbcscs_pkg::q_entry_t      push_entry
);

    dbcscs_pkg::scan_mode_t mode_reg, mode_next;
    logic slash_reg, slash_next;
    logic nl_reg, nl_next;
    logic sp_reg, sp_next;
    logic odd_reg, odd_next;
    logic prev_hi_reg, prev_hi_next;

    logic       accept;
    logic       act;
    logic [7:0] bc;
    logic       act_quote, act_slash, act_star, act_lf, act_space, act_tab;

    // normal-text classification of the current byte
    logic nb_emit, nb_nl, nb_sp;

    logic pre_slash;
    logic emit_b;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // A byte is structural unless it trails an odd high-byte run
    assign act = !(prev_hi_reg && odd_reg);
    assign bc  = (act && s_tdata == dbcscs_pkg::CH_CR) ? dbcscs_pkg::CH_LF : s_tdata;

    assign act_quote = act && bc == dbcscs_pkg::CH_QUOTE;
    assign act_slash = act && bc == dbcscs_pkg::CH_SLASH;
    assign act_star  = act && bc == dbcscs_pkg::CH_STAR;
    assign act_lf    = act && bc == dbcscs_pkg::CH_LF;
    assign act_space = act && bc == dbcscs_pkg::CH_SPACE;
    assign act_tab   = act && bc == dbcscs_pkg::CH_TAB;

    // Normal-text handling of one byte
    always_comb
    begin
        nb_emit = 1'b1;
        nb_nl   = 1'b0;
        nb_sp   = 1'b0;
        if (act_slash || act_tab)
        begin
            nb_emit = 1'b0;
        end
        else if (act_lf)
        begin
            nb_emit = !nl_reg;
            nb_nl   = 1'b1;
        end
        else if (act_space)
        begin
            nb_emit = !sp_reg;
            nb_sp   = 1'b1;
        end
    end

    // Next scan mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            dbcscs_pkg::MODE_STRING:
            begin
                if (act_quote)
                    mode_next = dbcscs_pkg::MODE_NORMAL;
            end
            dbcscs_pkg::MODE_LINE:
            begin
                if (act_lf)
                    mode_next = dbcscs_pkg::MODE_NORMAL;
            end
            dbcscs_pkg::MODE_BLOCK:
            begin
                if (act_star)
                    mode_next = dbcscs_pkg::MODE_STAR;
            end
            dbcscs_pkg::MODE_STAR:
            begin
                if (act_slash)
                    mode_next = dbcscs_pkg::MODE_NORMAL;
                else if (!act_star)
                    mode_next = dbcscs_pkg::MODE_BLOCK;
            end
            default:
            begin
                if (slash_reg && act_slash)
                    mode_next = dbcscs_pkg::MODE_LINE;
                else if (slash_reg && act_star)
                    mode_next = dbcscs_pkg::MODE_STAR;
                else if (act_quote)
                    mode_next = dbcscs_pkg::MODE_STRING;
                else
                    mode_next = dbcscs_pkg::MODE_NORMAL;
            end
        endcase
        if (s_tlast)
            mode_next = dbcscs_pkg::MODE_NORMAL;
    end

    // Emitted bytes and run/slash flags
    always_comb
    begin
        slash_next = slash_reg;
        nl_next    = nl_reg;
        sp_next    = sp_reg;
        pre_slash  = 1'b0;
        emit_b     = 1'b0;
        case (mode_reg)
            dbcscs_pkg::MODE_STRING:
            begin
                emit_b = 1'b1;
            end
            dbcscs_pkg::MODE_LINE:
            begin
                if (act_lf)
                begin
                    emit_b  = nb_emit;
                    nl_next = nb_nl;
                    sp_next = nb_sp;
                end
            end
            dbcscs_pkg::MODE_BLOCK,
            dbcscs_pkg::MODE_STAR:
            begin
                emit_b = 1'b0;
            end
            default:
            begin
                if (slash_reg && (act_slash || act_star))
                begin
                    slash_next = 1'b0;
                    nl_next    = 1'b0;
                    sp_next    = 1'b0;
                end
                else
                begin
                    pre_slash  = slash_reg;
                    slash_next = act_slash;
                    emit_b     = nb_emit;
                    nl_next    = nb_nl;
                    sp_next    = nb_sp;
                end
            end
        endcase
        if (s_tlast)
        begin
            slash_next = 1'b0;
            nl_next    = 1'b0;
            sp_next    = 1'b0;
        end
    end

    // High-byte run tracking
    always_comb
    begin
        odd_next     = (s_tdata >= dbcscs_pkg::CH_HIGH) ? !odd_reg : 1'b0;
        prev_hi_next = s_tdata > dbcscs_pkg::CH_HIGH;
        if (s_tlast)
        begin
            odd_next     = 1'b0;
            prev_hi_next = 1'b0;
        end
    end

    // Queue job for this word
    always_comb
    begin
        push                 = accept && (s_tlast || pre_slash || emit_b);
        push_entry.done      = s_tlast;
        push_entry.pre_slash = !s_tlast && pre_slash && emit_b;
        if (s_tlast)
        begin
            push_entry.bvalid = slash_reg;
            push_entry.data   = slash_reg ? dbcscs_pkg::CH_SLASH : 8'h00;
        end
        else
        begin
            push_entry.bvalid = 1'b1;
            push_entry.data   = emit_b ? bc : dbcscs_pkg::CH_SLASH;
        end
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= dbcscs_pkg::MODE_NORMAL;
            slash_reg   <= 1'b0;
            nl_reg      <= 1'b0;
            sp_reg      <= 1'b0;
            odd_reg     <= 1'b0;
            prev_hi_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            slash_reg   <= slash_next;
            nl_reg      <= nl_next;
            sp_reg      <= sp_next;
            odd_reg     <= odd_next;
            prev_hi_reg <= prev_hi_next;
        end
    end

endmodule

// ----- hw/rtl/dbcscs_queue.sv -----
module dbcscs_queue
#(
    parameter int DEPTH = dbcscs_pkg::QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  dbcscs_pkg::q_entry_t      push_entry,
    input  logic                      pop,
    output dbcscs_pkg::q_entry_t      head,
    output dbcscs_pkg::queue_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dbcscs_pkg::q_entry_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = count_reg == CNT_W'(DEPTH);
    assign q_status.empty = count_reg == '0;
    assign head           = entries[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/dbcscs_back.sv -----
module dbcscs_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dbcscs_pkg::queue_status_t q_status,
    input  dbcscs_pkg::q_entry_t      head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [7:0] out_byte
    output logic [1:0]                m_tuser,   // [0] byte_valid, [1] text_done
    output logic                      m_tlast    // run_last
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       bvalid_reg, bvalid_next;
    logic       done_reg, done_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic [7:0] second_data_reg, second_data_next;

    logic load;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !second_reg && !q_status.empty;

    // Output word selection: pending second half first, then queue head
    always_comb
    begin
        valid_next       = valid_reg;
        data_next        = data_reg;
        bvalid_next      = bvalid_reg;
        done_next        = done_reg;
        last_next        = last_reg;
        second_next      = second_reg;
        second_data_next = second_data_reg;
        if (load)
        begin
            if (second_reg)
            begin
                valid_next  = 1'b1;
                data_next   = second_data_reg;
                bvalid_next = 1'b1;
                done_next   = 1'b0;
                last_next   = 1'b1;
                second_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                valid_next = 1'b1;
                if (head.pre_slash)
                begin
                    data_next        = dbcscs_pkg::CH_SLASH;
                    bvalid_next      = 1'b1;
                    done_next        = 1'b0;
                    last_next        = 1'b0;
                    second_next      = 1'b1;
                    second_data_next = head.data;
                end
                else
                begin
                    data_next   = head.data;
                    bvalid_next = head.bvalid;
                    done_next   = head.done;
                    last_next   = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        data_reg        <= data_next;
        bvalid_reg      <= bvalid_next;
        done_reg        <= done_next;
        last_reg        <= last_next;
        second_data_reg <= second_data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {done_reg, bvalid_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/dbcs_aware_script_comment_stripper.sv -----
// Channel   Dir  tdata            tuser                          tlast
// s_        in   [7:0] text_byte  -                              end_of_text
// m_        out  [7:0] out_byte   [0] byte_valid, [1] text_done  run_last
//
// Input takes one byte word per cycle while the job queue has room.
// An input byte yields zero to two output words, one per cycle with m_tready high;
// only a byte flushing a held slash needs two. End of text always yields one word.
// A word passes through the queue and then the output register before it is presented.
// Reset is asynchronous, active low, and clears scanner and queue control state.
// Front and back stall independently through the queue of QUEUE_DEPTH jobs.
`include "dbcs_aware_script_comment_stripper_defines.svh"

module dbcs_aware_script_comment_stripper
#(
    parameter int QUEUE_DEPTH = dbcscs_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] text_byte
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] byte_valid, [1] text_done
    output logic       m_tlast     // run_last
);

    logic                      push;
    logic                      pop;
    dbcscs_pkg::q_entry_t      push_entry;
    dbcscs_pkg::q_entry_t      head;
    dbcscs_pkg::queue_status_t q_status;

    // Output word shapes used by the checks
    logic slash_word;
    logic closing_word;
    logic second_half;

    dbcscs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    dbcscs_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    dbcscs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign slash_word   = m_tuser[0] && !m_tuser[1] && m_tdata == dbcscs_pkg::CH_SLASH;
    assign closing_word = m_tuser[1] && m_tdata == 8'h00;
    assign second_half  = m_tvalid && m_tlast && !m_tuser[1];

    // End-of-text word is always the final word of its item
    `DBCSCS_ASSERT_IMPL(a_done_is_last, clk, rst_n, m_tvalid && m_tuser[1], m_tlast)
    // A non-final word can only be a flushed slash
    `DBCSCS_ASSERT_IMPL(a_first_is_slash, clk, rst_n, m_tvalid && !m_tlast, slash_word)
    // An empty word only closes the text and carries a zero byte
    `DBCSCS_ASSERT_IMPL(a_empty_word, clk, rst_n, m_tvalid && !m_tuser[0], closing_word)
    // The first half of a slash pair is followed by its second half
    `DBCSCS_ASSERT_NEXT(a_pair_follows, clk, rst_n, m_tvalid && m_tready && !m_tlast, second_half)

endmodule
